// ===== rtl/core/mmu_pkg.sv =====
// Shared types and constants for the Montgomery multiplier unit.
`default_nettype none
package mmu_pkg;
   localparam int WORD_W = 32;
   localparam logic [1:0] KIND_LOAD_MOD  = 2'd0;
   localparam logic [1:0] KIND_LOAD_OPS  = 2'd1;
   localparam logic [1:0] KIND_RUN_MUL   = 2'd2;
   localparam logic [1:0] KIND_RUN_FROM  = 2'd3;
   typedef logic [WORD_W-1:0] word_type;
endpackage
`default_nettype wire

// ===== rtl/core/montgomery_multiplier_unit.sv =====
// Top level of the word-serial Montgomery multiplier unit.
// Load requests give no response.
// A run computes every product on the single shared multiplier, then emits LIMBS words.
// Only one request is in work at a time; req_ready is low during a run and its output.
// Synchronous active-high reset clears the sequencer and the neg_inv_modulus register.
`default_nettype none
module montgomery_multiplier_unit
   import mmu_pkg::*;
#(
   parameter int LIMBS = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [5:0]  req_word_index,
   input  wire logic [31:0] req_word_a,
   input  wire logic [31:0] req_word_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_word,
   output logic [5:0]       rsp_result_index,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);
   localparam int IW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int CW = $clog2(LIMBS + 1);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLR   = 4'd1;
   localparam logic [3:0] ST_U1    = 4'd2;  // issue acc0 + ai*b0
   localparam logic [3:0] ST_U2    = 4'd3;  // issue low * minv
   localparam logic [3:0] ST_U3    = 4'd4;  // capture u
   localparam logic [3:0] ST_X     = 4'd5;  // issue acc[j] + ai*b[j] + c1
   localparam logic [3:0] ST_Y     = 4'd6;  // capture x, issue xlo + u*p[j] + c2
   localparam logic [3:0] ST_YW    = 4'd7;  // capture y
   localparam logic [3:0] ST_TOP   = 4'd8;
   localparam logic [3:0] ST_CMP   = 4'd9;
   localparam logic [3:0] ST_SUB   = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   word_type mod_mem [LIMBS];
   word_type a_mem   [LIMBS];
   word_type b_mem   [LIMBS];
   word_type acc_mem [LIMBS];

   logic [3:0]   state_ff, state_in;
   logic [CW-1:0] i_ff, i_in;       // row counter
   logic [CW-1:0] j_ff, j_in;       // word counter
   logic         from_ff, from_in;  // run converts out of Montgomery form
   word_type     minv_ff;
   word_type     ai_ff, ai_in;
   word_type     u_ff, u_in;
   word_type     c1_ff, c1_in;
   word_type     c2_ff, c2_in;
   logic         top_ff, top_in;
   logic         ge_ff, ge_in;      // running compare: acc >= p over words seen
   logic         brw_ff, brw_in;
   logic         rv_ff, rv_in;
   word_type     rw_ff, rw_in;
   logic [5:0]   ri_ff, ri_in;
   logic         rl_ff, rl_in;

   logic [IW-1:0] ji, ii;
   word_type     accj, modj, bj, aj;
   word_type     ma, mb, mc, md;
   logic [2*WORD_W-1:0] prod;
   logic         acc_we;
   logic [IW-1:0] acc_wa;
   word_type     acc_wd;
   logic [WORD_W:0] diff;
   logic [WORD_W+1:0] topsum;
   logic         do_sub;

   assign ji = j_ff[IW-1:0];
   assign ii = i_ff[IW-1:0];
   assign accj = acc_mem[ji];
   assign modj = mod_mem[ji];
   assign bj   = b_mem[ji];
   assign aj   = a_mem[ii];

   mmu_mac u_mac (
      .clock (clock),
      .mul_a (ma),
      .mul_b (mb),
      .add_c (mc),
      .add_d (md),
      .prod  (prod)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_result_word = rw_ff;
   assign rsp_result_index = ri_ff;
   assign rsp_last = rl_ff;

   assign diff = {1'b0, accj} - {1'b0, modj} - {{WORD_W{1'b0}}, brw_ff};
   assign topsum = {{(WORD_W+1){1'b0}}, top_ff} + {2'b00, c1_ff} + {2'b00, c2_ff};
   assign do_sub = top_ff | ge_ff;

   // Store writes for load requests, and accumulator writes from the sequencer.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready && ({1'b0, req_word_index} < 7'(LIMBS))) begin
         if (req_kind == KIND_LOAD_MOD) begin
            mod_mem[req_word_index[IW-1:0]] <= req_word_a;
         end else if (req_kind == KIND_LOAD_OPS) begin
            a_mem[req_word_index[IW-1:0]] <= req_word_a;
            b_mem[req_word_index[IW-1:0]] <= req_word_b;
         end
      end
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minv_ff <= '0;
      end else if (csr_write_enable) begin
         minv_ff <= csr_write_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      from_in = from_ff;
      ai_in = ai_ff;
      u_in = u_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      top_in = top_ff;
      ge_in = ge_ff;
      brw_in = brw_ff;
      rv_in = rv_ff;
      rw_in = rw_ff;
      ri_in = ri_ff;
      rl_in = rl_ff;
      ma = '0;
      mb = '0;
      mc = '0;
      md = '0;
      acc_we = 1'b0;
      acc_wa = ji;
      acc_wd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ((req_kind == KIND_RUN_MUL) || (req_kind == KIND_RUN_FROM))) begin
               from_in = (req_kind == KIND_RUN_FROM);
               j_in = '0;
               i_in = '0;
               top_in = 1'b0;
               state_in = ST_CLR;
            end
         end
         ST_CLR: begin
            acc_we = 1'b1;
            j_in = j_ff + 1'b1;
            if (j_ff == CW'(LIMBS - 1)) begin
               j_in = '0;
               state_in = ST_U1;
            end
         end
         ST_U1: begin
            // Row operand: a_i, or 1 then 0 for the conversion run.
            if (from_ff) begin
               ai_in = (i_ff == '0) ? word_type'(1) : '0;
            end else begin
               ai_in = aj;
            end
            ma = ai_in;
            mb = bj;
            mc = accj;
            state_in = ST_U2;
         end
         ST_U2: begin
            ma = prod[WORD_W-1:0];
            mb = minv_ff;
            state_in = ST_U3;
         end
         ST_U3: begin
            u_in = prod[WORD_W-1:0];
            c1_in = '0;
            c2_in = '0;
            state_in = ST_X;
         end
         ST_X: begin
            ma = ai_ff;
            mb = bj;
            mc = accj;
            md = c1_ff;
            state_in = ST_Y;
         end
         ST_Y: begin
            c1_in = prod[2*WORD_W-1:WORD_W];
            ma = u_ff;
            mb = modj;
            mc = prod[WORD_W-1:0];
            md = c2_ff;
            state_in = ST_YW;
         end
         ST_YW: begin
            c2_in = prod[2*WORD_W-1:WORD_W];
            if (j_ff != '0) begin
               acc_we = 1'b1;
               acc_wa = ji - 1'b1;
               acc_wd = prod[WORD_W-1:0];
            end
            j_in = j_ff + 1'b1;
            state_in = ST_X;
            if (j_ff == CW'(LIMBS - 1)) begin
               state_in = ST_TOP;
            end
         end
         ST_TOP: begin
            acc_we = 1'b1;
            acc_wa = IW'(LIMBS - 1);
            acc_wd = topsum[WORD_W-1:0];
            top_in = topsum[WORD_W];
            j_in = '0;
            i_in = i_ff + 1'b1;
            state_in = ST_U1;
            if (i_ff == CW'(LIMBS - 1)) begin
               ge_in = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // Low word first: later (higher) words override when they differ.
            if (accj > modj) begin
               ge_in = 1'b1;
            end else if (accj < modj) begin
               ge_in = 1'b0;
            end
            j_in = j_ff + 1'b1;
            if (j_ff == CW'(LIMBS - 1)) begin
               j_in = '0;
               brw_in = 1'b0;
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (do_sub) begin
               acc_we = 1'b1;
               acc_wd = diff[WORD_W-1:0];
               brw_in = diff[WORD_W];
            end
            j_in = j_ff + 1'b1;
            if (j_ff == CW'(LIMBS - 1)) begin
               j_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               if (j_ff == CW'(LIMBS)) begin
                  rv_in = 1'b0;
                  top_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rv_in = 1'b1;
                  rw_in = accj;
                  ri_in = 6'(j_ff);
                  rl_in = (j_ff == CW'(LIMBS - 1));
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         top_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         i_ff <= i_in;
         j_ff <= j_in;
         top_ff <= top_in;
      end
      from_ff <= from_in;
      ai_ff <= ai_in;
      u_ff <= u_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      ge_ff <= ge_in;
      brw_ff <= brw_in;
      rw_ff <= rw_in;
      ri_ff <= ri_in;
      rl_ff <= rl_in;
   end

   // A response is only ever presented during the output phase.
   a_rsp_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_OUT || $past(state_ff) == ST_OUT))
      else $error("response outside output phase");
   // No request is taken while a run is active.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready during run");
   // A stalled response holds its word.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_result_word))
      else $error("response changed under stall");
endmodule
`default_nettype wire

// ===== rtl/core/mmu_mac.sv =====
// Registered multiply-accumulate unit: p = a*b + c + d.
`default_nettype none
module mmu_mac
   import mmu_pkg::*;
(
   input  wire logic                clock,
   input  wire word_type            mul_a,
   input  wire word_type            mul_b,
   input  wire word_type            add_c,
   input  wire word_type            add_d,
   output logic [2*WORD_W-1:0]      prod
);
   logic [2*WORD_W-1:0] prod_ff;
   logic [2*WORD_W-1:0] prod_in;

   // a*b + c + d never exceeds 2^64 - 1.
   assign prod_in = ({{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b})
                  + {{WORD_W{1'b0}}, add_c} + {{WORD_W{1'b0}}, add_d};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
   assign prod = prod_ff;
endmodule
`default_nettype wire

// ===== sim/tb_montgomery_multiplier_unit.sv =====
// Self-checking testbench for the Montgomery multiplier unit with a word-level product model.
`timescale 1ns / 1ps

// Expected-response store and word-serial product model for the unit.
class mont_scoreboard;
   typedef struct {
      logic [31:0] word;
      logic [5:0]  index;
      logic        last;
   } rsp_word_type;

   int unsigned limbs;
   logic [31:0] neg_inv;
   logic [31:0] mod_words[64];
   logic [31:0] op_a_words[64];
   logic [31:0] op_b_words[64];
   logic [31:0] acc[64];
   logic        carry;
   rsp_word_type expected_words[$];
   int unsigned fail_count;

   function new(int unsigned n);
      limbs = n;
      neg_inv = '0;
      carry = 1'b0;
      fail_count = 0;
   endfunction

   function int unsigned pending();
      return expected_words.size();
   endfunction

   // One outer row: acc = (acc + ai*b + u*p) / 2^32.
   function void mont_row(logic [31:0] ai);
      logic [63:0] x, y, top, c1, c2;
      logic [31:0] u;
      c1 = '0;
      c2 = '0;
      x = {32'd0, acc[0]} + {32'd0, ai} * {32'd0, op_b_words[0]};
      u = x[31:0];
      y = {32'd0, u} * {32'd0, neg_inv};
      u = y[31:0];
      for (int j = 0; j < limbs; j++) begin
         x = {32'd0, acc[j]} + {32'd0, ai} * {32'd0, op_b_words[j]} + c1;
         c1 = x >> 32;
         y = {32'd0, x[31:0]} + {32'd0, u} * {32'd0, mod_words[j]} + c2;
         c2 = y >> 32;
         if (j > 0) begin
            acc[j-1] = y[31:0];
         end
      end
      top = {63'd0, carry} + c1 + c2;
      acc[limbs-1] = top[31:0];
      carry = top[32];
   endfunction

   function bit acc_not_below_modulus();
      for (int i = limbs - 1; i >= 0; i--) begin
         if (acc[i] > mod_words[i]) return 1'b1;
         if (acc[i] < mod_words[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Records an accepted request and queues the words that a run produces.
   function void note_request(logic [1:0] kind, logic [5:0] idx,
                              logic [31:0] wa, logic [31:0] wb);
      logic [63:0] d;
      logic        borrow;
      rsp_word_type w;
      if (kind == mmu_pkg::KIND_LOAD_MOD || kind == mmu_pkg::KIND_LOAD_OPS) begin
         if (idx < limbs) begin
            if (kind == mmu_pkg::KIND_LOAD_MOD) begin
               mod_words[idx] = wa;
            end else begin
               op_a_words[idx] = wa;
               op_b_words[idx] = wb;
            end
         end
         return;
      end
      for (int i = 0; i < limbs; i++) acc[i] = '0;
      carry = 1'b0;
      for (int i = 0; i < limbs; i++) begin
         if (kind == mmu_pkg::KIND_RUN_MUL) mont_row(op_a_words[i]);
         else mont_row((i == 0) ? 32'd1 : 32'd0);
      end
      if (carry || acc_not_below_modulus()) begin
         borrow = 1'b0;
         for (int i = 0; i < limbs; i++) begin
            d = {32'd0, acc[i]} - {32'd0, mod_words[i]} - {63'd0, borrow};
            acc[i] = d[31:0];
            borrow = d[63];
         end
         carry = 1'b0;
      end
      for (int i = 0; i < limbs; i++) begin
         w.word = acc[i];
         w.index = i[5:0];
         w.last = (i == limbs - 1);
         expected_words.push_back(w);
      end
   endfunction

   // Compares one accepted response word with the oldest expectation.
   function void check_response(logic [31:0] word, logic [5:0] idx, logic last);
      rsp_word_type w;
      if (expected_words.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected response word %h index %0d", $time, word, idx);
         return;
      end
      w = expected_words.pop_front();
      if (word !== w.word || idx !== w.index || last !== w.last) begin
         fail_count++;
         if (fail_count < 30) begin
            $display("%0t: mismatch expected word %h index %0d last %0b, got %h %0d %0b",
                     $time, w.word, w.index, w.last, word, idx, last);
         end
      end
   endfunction
endclass

module tb_montgomery_multiplier_unit;
   import mmu_pkg::*;

   localparam int LIMBS = 32;
   // A run passes with no handshake at all, and the receiver may then hold off as well, so the
   // idle limit is set well above the length of a run.
   localparam int IDLE_LIMIT = 60000;
   localparam int LONG_HOLD = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [5:0]  req_word_index;
   logic [31:0] req_word_a;
   logic [31:0] req_word_b;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_word;
   logic [5:0]  rsp_result_index;
   logic        rsp_last;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   mont_scoreboard sb;
   bit          quiet;       // When set, neither side idles.
   bit          hold_request;
   int unsigned request_count;

   montgomery_multiplier_unit #(.LIMBS(LIMBS)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_word_index(req_word_index),
      .req_word_a(req_word_a),
      .req_word_b(req_word_b),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_word(rsp_result_word),
      .rsp_result_index(rsp_result_index),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Gap lengths are mostly zero or short, with an occasional long one.
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (quiet || r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Minus the inverse of an odd word modulo 2^32, by Newton iteration.
   function automatic logic [31:0] neg_inverse(logic [31:0] p0);
      logic [31:0] x;
      x = p0;
      for (int k = 0; k < 5; k++) x = x * (32'd2 - p0 * x);
      return -x;
   endfunction

   // Offers one request and returns at the edge where it is accepted.
   task automatic send_request(logic [1:0] kind, logic [5:0] idx,
                               logic [31:0] wa, logic [31:0] wb);
      int unsigned gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_word_index <= idx;
      req_word_a <= wa;
      req_word_b <= wb;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, idx, wa, wb);
      request_count++;
   endtask

   // Stops offering requests and waits until every expected word has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // The register is written only with the unit idle: the task drains first and waits before the write.
   task automatic write_neg_inv(logic [31:0] value);
      drain();
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.neg_inv = value;
   endtask

   // A run request carries random content in the fields the unit ignores.
   task automatic send_run(logic [1:0] kind);
      send_request(kind, 6'($urandom), $urandom, $urandom);
   endtask

   // Loads a whole modulus and operand set in a random word order, with some ignored
   // out-of-range loads mixed in.
   task automatic load_all(logic [31:0] p[LIMBS], logic [31:0] a[LIMBS], logic [31:0] b[LIMBS]);
      int unsigned order[LIMBS];
      int unsigned t, s;
      for (int i = 0; i < LIMBS; i++) order[i] = i;
      for (int i = LIMBS - 1; i > 0; i--) begin
         s = $urandom_range(0, i);
         t = order[i];
         order[i] = order[s];
         order[s] = t;
      end
      for (int i = 0; i < LIMBS; i++) begin
         send_request(KIND_LOAD_MOD, order[i][5:0], p[order[i]], $urandom);
         send_request(KIND_LOAD_OPS, order[LIMBS-1-i][5:0], a[order[LIMBS-1-i]],
                      b[order[LIMBS-1-i]]);
         if ($urandom_range(0, 7) == 0) begin
            send_request(2'($urandom_range(0, 1)), 6'($urandom_range(LIMBS, 63)), $urandom,
                         $urandom);
         end
      end
   endtask

   // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (gap_length() == 0);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_result_word, rsp_result_index, rsp_last);
         end
      end
   end

   // Watchdog: ends the run if no request or response moves for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] p[LIMBS];
      logic [31:0] a[LIMBS];
      logic [31:0] b[LIMBS];
      int unsigned n;
      sb = new(LIMBS);
      quiet = 1'b0;
      hold_request = 1'b0;
      request_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD_MOD;
      req_word_index = '0;
      req_word_a = '0;
      req_word_b = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A modulus of all ones has minus inverse 1. Operands equal to the
      // modulus hit the equal case of the final compare, and all-zero operands give zero.
      write_neg_inv(32'hffffffff);
      for (int i = 0; i < LIMBS; i++) begin
         p[i] = 32'hffffffff;
         a[i] = 32'hffffffff;
         b[i] = 32'hffffffff;
      end
      load_all(p, a, b);
      send_request(KIND_LOAD_MOD, 6'd63, 32'h0, 32'hffffffff);
      send_request(KIND_LOAD_OPS, 6'(LIMBS), 32'h0, 32'h0);
      send_run(KIND_RUN_MUL);
      write_neg_inv(neg_inverse(32'hffffffff));
      send_run(KIND_RUN_MUL);
      send_run(KIND_RUN_FROM);
      // Zero operands, then the smallest odd modulus with a zero register.
      for (int i = 0; i < LIMBS; i++) begin
         send_request(KIND_LOAD_OPS, i[5:0], 32'h0, 32'h0);
      end
      send_run(KIND_RUN_MUL);
      send_request(KIND_LOAD_MOD, 6'd0, 32'h1, 32'h0);
      for (int i = 1; i < LIMBS; i++) send_request(KIND_LOAD_MOD, i[5:0], 32'h0, 32'h0);
      write_neg_inv(32'h0);
      send_run(KIND_RUN_FROM);

      // Random part: fresh moduli and operands, partial updates, both run kinds.
      n = 0;
      while (request_count < 260) begin
         quiet = ($urandom_range(0, 3) == 0);
         if (n == 0 || $urandom_range(0, 2) == 0) begin
            for (int i = 0; i < LIMBS; i++) begin
               p[i] = $urandom;
               a[i] = $urandom;
               b[i] = $urandom;
            end
            p[0][0] = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) == 0) begin
               a[LIMBS-1] = p[LIMBS-1];
               b[LIMBS-1] = p[LIMBS-1];
            end
            write_neg_inv(p[0][0] ? neg_inverse(p[0]) : $urandom);
            load_all(p, a, b);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_request(KIND_LOAD_OPS, 6'($urandom_range(0, 63)), $urandom, $urandom);
            end
         end
         if (n == 1) begin
            // The receiver holds off while the sender keeps offering runs.
            hold_request = 1'b1;
            send_run(KIND_RUN_MUL);
            send_run(KIND_RUN_FROM);
         end
         send_run($urandom_range(0, 1) ? KIND_RUN_MUL : KIND_RUN_FROM);
         if ($urandom_range(0, 2) == 0) drain();
         n++;
      end

      drain();
      repeat (50) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/mmu_pkg.sv
rtl/core/mmu_mac.sv
rtl/core/montgomery_multiplier_unit.sv
sim/tb_montgomery_multiplier_unit.sv
